### rtl/lfp_pkg.sv
package lfp_pkg;

   localparam int NUM_SENSORS = 8;
   localparam int SENSOR_W    = 16;
   localparam int WEIGHT_W    = 8;
   localparam int WSUM_W      = 11;  // eight Q4.4 weights summed
   localparam int CNT_W       = 4;   // holds 0..NUM_SENSORS
   localparam int QUO_W       = 15;  // |sum * 16| <= 16384
   localparam int OPND_W      = 17;
   localparam int PROD_W      = 2 * OPND_W;
   localparam int ACC_W       = PROD_W + 2;

   localparam logic [3:0] DIV_STEPS = 4'(QUO_W);
   localparam logic [3:0] MAC_STEPS = 4'd3;

   // Q8.8 error thresholds: 0.6, 1.5, 3.0
   localparam logic [QUO_W-1:0] DEAD_ZONE = 15'd153;
   localparam logic [QUO_W-1:0] ERR_MID   = 15'd384;
   localparam logic [QUO_W-1:0] ERR_HI    = 15'd768;

   // Q8.8 integral limits: 20, 50, 80
   localparam logic signed [OPND_W-1:0] INTEG_LIM_LO  = 17'sd5120;
   localparam logic signed [OPND_W-1:0] INTEG_LIM_MID = 17'sd12800;
   localparam logic signed [OPND_W-1:0] INTEG_LIM_HI  = 17'sd20480;

   typedef enum logic [2:0] {
      CSR_PROP_GAIN       = 3'd0,
      CSR_INTEG_GAIN      = 3'd1,
      CSR_DERIV_GAIN      = 3'd2,
      CSR_CRUISE_SPEED    = 3'd3,
      CSR_SPEED_CAP       = 3'd4,
      CSR_LINE_LEVEL      = 3'd5,
      CSR_CHANNEL_WEIGHTS = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      ALU_IDLE     = 2'd0,
      ALU_DIV_LOAD = 2'd1,
      ALU_DIV_STEP = 2'd2,
      ALU_MUL      = 2'd3
   } alu_op_type;

   typedef struct packed {
      alu_op_type                 op;
      logic signed [OPND_W-1:0]   opa;
      logic signed [OPND_W-1:0]   opb;
      logic [CNT_W-1:0]           divisor;
   } alu_cmd_type;

   typedef struct packed {
      logic                       differ;
      logic [CNT_W-1:0]           count;
      logic signed [WSUM_W-1:0]   wsum;
   } frame_info_type;

endpackage

### rtl/lfp_frame.sv
module lfp_frame #(
   parameter int NUM_CHANNELS = 8
) (
   input  logic [lfp_pkg::NUM_SENSORS-1:0][lfp_pkg::SENSOR_W-1:0] sensors,
   input  logic [lfp_pkg::SENSOR_W-1:0]                           line_level,
   input  logic [lfp_pkg::NUM_SENSORS*lfp_pkg::WEIGHT_W-1:0]      weights,
   output lfp_pkg::frame_info_type                                info
);

   logic                                 differ;
   logic [lfp_pkg::CNT_W-1:0]            count;
   logic signed [lfp_pkg::WSUM_W-1:0]    wsum;
   logic [lfp_pkg::WEIGHT_W-1:0]         w;

   always_comb begin
      differ = 1'b0;
      count  = '0;
      wsum   = '0;
      w      = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (i > 0 && sensors[i] != sensors[0]) begin
            differ = 1'b1;
         end
         if (sensors[i] == line_level) begin
            w     = weights[i*lfp_pkg::WEIGHT_W +: lfp_pkg::WEIGHT_W];
            count = count + 4'd1;
            wsum  = wsum + $signed({{(lfp_pkg::WSUM_W-lfp_pkg::WEIGHT_W){w[7]}}, w});
         end
      end
      info.differ = differ;
      info.count  = count;
      info.wsum   = wsum;
   end

endmodule

### rtl/lfp_alu.sv
module lfp_alu (
   input  logic                                 clock,
   input  lfp_pkg::alu_cmd_type                 cmd,
   output logic [lfp_pkg::QUO_W-1:0]            quotient,
   output logic signed [lfp_pkg::PROD_W-1:0]    product
);

   logic [lfp_pkg::CNT_W-1:0]           rem_ff, rem_in;
   logic [lfp_pkg::QUO_W-1:0]           quo_ff, quo_in;
   logic signed [lfp_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic [lfp_pkg::CNT_W:0]             trial;
   logic [lfp_pkg::CNT_W:0]             diff;
   logic                                fits;

   // one restoring division step: bring down the next dividend bit
   assign trial = {rem_ff, quo_ff[lfp_pkg::QUO_W-1]};
   assign diff  = trial - {1'b0, cmd.divisor};
   assign fits  = trial >= {1'b0, cmd.divisor};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      prod_in = prod_ff;
      unique case (cmd.op)
         lfp_pkg::ALU_IDLE: begin
         end
         lfp_pkg::ALU_DIV_LOAD: begin
            rem_in = '0;
            quo_in = cmd.opa[lfp_pkg::QUO_W-1:0];
         end
         lfp_pkg::ALU_DIV_STEP: begin
            rem_in = fits ? diff[lfp_pkg::CNT_W-1:0] : trial[lfp_pkg::CNT_W-1:0];
            quo_in = {quo_ff[lfp_pkg::QUO_W-2:0], fits};
         end
         lfp_pkg::ALU_MUL: begin
            prod_in = cmd.opa * cmd.opb;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      prod_ff <= prod_in;
   end

   assign quotient = quo_ff;
   assign product  = prod_ff;

endmodule

### rtl/line_follow_pid_steering.sv
// channel | ports                          | direction | handshake
// req     | req_sensor_0 .. req_sensor_7   | in        | req_valid / req_ready
// rsp     | rsp_left_wheel, rsp_right_wheel| out       | rsp_valid / rsp_ready
//         | rsp_held_stopped               |           |
// csr     | csr_index, csr_wr_data         | in        | csr_wr_en, no wait
//
// A locked frame with all readings equal goes from S_SCAN straight to S_OUT.
// Otherwise the shared unit divides one quotient bit per cycle in S_DIV, which is
// skipped when no channel is on the line, and does its three multiplies in S_MAC.
// One request is in flight at a time; req_ready returns once the result is taken.
// The result sits in the output register until rsp_ready.
// Synchronous reset locks the block and clears integral, previous error and CSRs.
module line_follow_pid_steering #(
   parameter int NUM_CHANNELS = 8
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic [15:0]         req_sensor_0,
   input  logic [15:0]         req_sensor_1,
   input  logic [15:0]         req_sensor_2,
   input  logic [15:0]         req_sensor_3,
   input  logic [15:0]         req_sensor_4,
   input  logic [15:0]         req_sensor_5,
   input  logic [15:0]         req_sensor_6,
   input  logic [15:0]         req_sensor_7,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [15:0]  rsp_left_wheel,
   output logic signed [15:0]  rsp_right_wheel,
   output logic                rsp_held_stopped,

   input  logic                csr_wr_en,
   input  logic [2:0]          csr_index,
   input  logic [63:0]         csr_wr_data
);

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_SCAN  = 9'b000000010,
      S_DIV   = 9'b000000100,
      S_POST  = 9'b000001000,
      S_INTEG = 9'b000010000,
      S_MAC   = 9'b000100000,
      S_FIN   = 9'b001000000,
      S_CLAMP = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

   // control and architectural state
   state_type           state_ff, state_in;
   logic                lock_ff, lock_in;
   logic signed [15:0]  integ_ff, integ_in;
   logic signed [15:0]  prev_ff, prev_in;
   logic [3:0]          step_ff, step_in;
   logic [15:0]         prop_gain_ff, prop_gain_in;
   logic [15:0]         integ_gain_ff, integ_gain_in;
   logic [15:0]         deriv_gain_ff, deriv_gain_in;
   logic signed [15:0]  cruise_ff, cruise_in;
   logic [14:0]         speed_cap_ff, speed_cap_in;
   logic [15:0]         line_level_ff, line_level_in;
   logic [63:0]         weights_ff, weights_in;

   // datapath registers
   logic [lfp_pkg::NUM_SENSORS-1:0][lfp_pkg::SENSOR_W-1:0] sensor_ff, sensor_in;
   logic [lfp_pkg::CNT_W-1:0]          count_ff, count_in;
   logic                               neg_ff, neg_in;
   logic signed [15:0]                 err_ff, err_in;
   logic [lfp_pkg::QUO_W-1:0]          mag_ff, mag_in;
   logic signed [16:0]                 deriv_ff, deriv_in;
   logic signed [lfp_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic signed [20:0]                 pid_ff, pid_in;
   logic signed [15:0]                 left_ff, left_in;
   logic signed [15:0]                 right_ff, right_in;
   logic                               held_ff, held_in;

   lfp_pkg::frame_info_type            info;
   lfp_pkg::alu_cmd_type               cmd;
   logic [lfp_pkg::QUO_W-1:0]          quotient;
   logic signed [lfp_pkg::PROD_W-1:0]  product;

   // combinational temporaries
   logic signed [14:0]                 scaled;
   logic signed [15:0]                 scaled_ext;
   logic signed [15:0]                 err_raw;
   logic signed [15:0]                 err_abs;
   logic                               flip;
   logic signed [16:0]                 integ_sum;
   logic signed [16:0]                 integ_lim;
   logic signed [lfp_pkg::ACC_W-1:0]   acc_mag;
   logic [19:0]                        q_mag;
   logic signed [21:0]                 lsum;
   logic signed [21:0]                 rsum;

   function automatic logic signed [15:0] clamp_speed(input logic signed [21:0] v,
                                                      input logic [14:0] cap);
      logic signed [21:0] lim;
      lim = $signed({7'd0, cap});
      if (v > lim) begin
         return lim[15:0];
      end else if (v < -lim) begin
         return 16'(-lim);
      end
      return v[15:0];
   endfunction

   lfp_frame #(
      .NUM_CHANNELS(NUM_CHANNELS)
   ) u_frame (
      .sensors    (sensor_ff),
      .line_level (line_level_ff),
      .weights    (weights_ff),
      .info       (info)
   );

   lfp_alu u_alu (
      .clock    (clock),
      .cmd      (cmd),
      .quotient (quotient),
      .product  (product)
   );

   assign scaled     = {info.wsum, 4'b0000};
   assign scaled_ext = {scaled[14], scaled};

   // shared unit command
   always_comb begin
      cmd.op      = lfp_pkg::ALU_IDLE;
      cmd.opa     = '0;
      cmd.opb     = '0;
      cmd.divisor = count_ff;
      unique case (state_ff)
         S_SCAN: begin
            cmd.op  = lfp_pkg::ALU_DIV_LOAD;
            cmd.opa = {1'b0, (scaled_ext[15] ? -scaled_ext : scaled_ext)};
         end
         S_DIV: begin
            cmd.op = lfp_pkg::ALU_DIV_STEP;
         end
         S_MAC: begin
            priority if (step_ff == 4'd0) begin
               cmd.op  = lfp_pkg::ALU_MUL;
               cmd.opa = $signed({1'b0, prop_gain_ff});
               cmd.opb = {err_ff[15], err_ff};
            end else if (step_ff == 4'd1) begin
               cmd.op  = lfp_pkg::ALU_MUL;
               cmd.opa = $signed({1'b0, integ_gain_ff});
               cmd.opb = {integ_ff[15], integ_ff};
            end else if (step_ff == 4'd2) begin
               cmd.op  = lfp_pkg::ALU_MUL;
               cmd.opa = $signed({1'b0, deriv_gain_ff});
               cmd.opb = deriv_ff;
            end else begin
               cmd.op = lfp_pkg::ALU_IDLE;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      lock_in       = lock_ff;
      integ_in      = integ_ff;
      prev_in       = prev_ff;
      step_in       = step_ff;
      prop_gain_in  = prop_gain_ff;
      integ_gain_in = integ_gain_ff;
      deriv_gain_in = deriv_gain_ff;
      cruise_in     = cruise_ff;
      speed_cap_in  = speed_cap_ff;
      line_level_in = line_level_ff;
      weights_in    = weights_ff;
      sensor_in     = sensor_ff;
      count_in      = count_ff;
      neg_in        = neg_ff;
      err_in        = err_ff;
      mag_in        = mag_ff;
      deriv_in      = deriv_ff;
      acc_in        = acc_ff;
      pid_in        = pid_ff;
      left_in       = left_ff;
      right_in      = right_ff;
      held_in       = held_ff;

      err_raw   = neg_ff ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
      if (count_ff == '0) begin
         err_raw = prev_ff;
      end
      err_abs   = err_raw[15] ? -err_raw : err_raw;
      flip      = (prev_ff > 16'sd0 && err_ff < 16'sd0) ||
                  (prev_ff < 16'sd0 && err_ff > 16'sd0);
      integ_sum = (flip ? 17'sd0 : {integ_ff[15], integ_ff}) + {err_ff[15], err_ff};
      integ_lim = (mag_ff > lfp_pkg::ERR_HI)  ? lfp_pkg::INTEG_LIM_HI  :
                  (mag_ff > lfp_pkg::ERR_MID) ? lfp_pkg::INTEG_LIM_MID :
                                                lfp_pkg::INTEG_LIM_LO;
      acc_mag   = acc_ff[lfp_pkg::ACC_W-1] ? -acc_ff : acc_ff;
      q_mag     = acc_mag[lfp_pkg::ACC_W-1:16];
      lsum      = {{6{cruise_ff[15]}}, cruise_ff} + {pid_ff[20], pid_ff};
      rsum      = {{6{cruise_ff[15]}}, cruise_ff} - {pid_ff[20], pid_ff};

      if (csr_wr_en) begin
         unique case (lfp_pkg::csr_index_type'(csr_index))
            lfp_pkg::CSR_PROP_GAIN:       prop_gain_in  = csr_wr_data[15:0];
            lfp_pkg::CSR_INTEG_GAIN:      integ_gain_in = csr_wr_data[15:0];
            lfp_pkg::CSR_DERIV_GAIN:      deriv_gain_in = csr_wr_data[15:0];
            lfp_pkg::CSR_CRUISE_SPEED:    cruise_in     = $signed(csr_wr_data[15:0]);
            lfp_pkg::CSR_SPEED_CAP:       speed_cap_in  = csr_wr_data[14:0];
            lfp_pkg::CSR_LINE_LEVEL:      line_level_in = csr_wr_data[15:0];
            lfp_pkg::CSR_CHANNEL_WEIGHTS: weights_in    = csr_wr_data;
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               sensor_in = {req_sensor_7, req_sensor_6, req_sensor_5, req_sensor_4,
                            req_sensor_3, req_sensor_2, req_sensor_1, req_sensor_0};
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            count_in = info.count;
            neg_in   = info.wsum[lfp_pkg::WSUM_W-1];
            if (lock_ff && !info.differ) begin
               // hold the wheels, leave the loop state alone
               left_in  = '0;
               right_in = '0;
               held_in  = 1'b1;
               state_in = S_OUT;
            end else begin
               lock_in = 1'b0;
               held_in = 1'b0;
               step_in = '0;
               state_in = (info.count == '0) ? S_POST : S_DIV;
            end
         end
         S_DIV: begin
            step_in = step_ff + 4'd1;
            if (step_ff == lfp_pkg::DIV_STEPS - 4'd1) begin
               state_in = S_POST;
            end
         end
         S_POST: begin
            if (err_abs[14:0] <= lfp_pkg::DEAD_ZONE) begin
               err_in = '0;
               mag_in = '0;
            end else begin
               err_in = err_raw;
               mag_in = err_abs[14:0];
            end
            state_in = S_INTEG;
         end
         S_INTEG: begin
            if (integ_sum > integ_lim) begin
               integ_in = integ_lim[15:0];
            end else if (integ_sum < -integ_lim) begin
               integ_in = 16'(-integ_lim);
            end else begin
               integ_in = integ_sum[15:0];
            end
            deriv_in = {err_ff[15], err_ff} - {prev_ff[15], prev_ff};
            prev_in  = err_ff;
            acc_in   = '0;
            step_in  = '0;
            state_in = S_MAC;
         end
         S_MAC: begin
            // accumulate the product issued in the previous cycle
            step_in = step_ff + 4'd1;
            if (step_ff != 4'd0) begin
               acc_in = acc_ff + {{2{product[lfp_pkg::PROD_W-1]}}, product};
            end
            if (step_ff == lfp_pkg::MAC_STEPS) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            // truncate toward zero
            pid_in   = acc_ff[lfp_pkg::ACC_W-1] ? -$signed({1'b0, q_mag})
                                                 : $signed({1'b0, q_mag});
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            left_in  = clamp_speed(lsum, speed_cap_ff);
            right_in = clamp_speed(rsum, speed_cap_ff);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         lock_ff       <= 1'b1;
         integ_ff      <= '0;
         prev_ff       <= '0;
         step_ff       <= '0;
         prop_gain_ff  <= '0;
         integ_gain_ff <= '0;
         deriv_gain_ff <= '0;
         cruise_ff     <= '0;
         speed_cap_ff  <= '0;
         line_level_ff <= '0;
         weights_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         lock_ff       <= lock_in;
         integ_ff      <= integ_in;
         prev_ff       <= prev_in;
         step_ff       <= step_in;
         prop_gain_ff  <= prop_gain_in;
         integ_gain_ff <= integ_gain_in;
         deriv_gain_ff <= deriv_gain_in;
         cruise_ff     <= cruise_in;
         speed_cap_ff  <= speed_cap_in;
         line_level_ff <= line_level_in;
         weights_ff    <= weights_in;
      end
   end

   always_ff @(posedge clock) begin
      sensor_ff <= sensor_in;
      count_ff  <= count_in;
      neg_ff    <= neg_in;
      err_ff    <= err_in;
      mag_ff    <= mag_in;
      deriv_ff  <= deriv_in;
      acc_ff    <= acc_in;
      pid_ff    <= pid_in;
      left_ff   <= left_in;
      right_ff  <= right_in;
      held_ff   <= held_in;
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = (state_ff == S_OUT);
   assign rsp_left_wheel   = left_ff;
   assign rsp_right_wheel  = right_ff;
   assign rsp_held_stopped = held_ff;

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request accepted while a response is pending");

   a_held_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_held_stopped |-> rsp_left_wheel == 16'sd0 &&
                                        rsp_right_wheel == 16'sd0 && lock_ff)
      else $error("held response with nonzero speed or while unlocked");

   a_lock_sticky: assert property (@(posedge clock) disable iff (reset)
      !lock_ff |=> !lock_ff)
      else $error("lock came back without reset");

   a_speed_capped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $signed(rsp_left_wheel) <= $signed({1'b0, speed_cap_ff}) &&
                    $signed(rsp_left_wheel) >= -$signed({1'b0, speed_cap_ff}) &&
                    $signed(rsp_right_wheel) <= $signed({1'b0, speed_cap_ff}) &&
                    $signed(rsp_right_wheel) >= -$signed({1'b0, speed_cap_ff}))
      else $error("wheel speed beyond cap");

endmodule
